// File: sv/msd_pkg.sv
`default_nettype none

package msd_pkg;

   // field widths of one transfer
   localparam int CODE_BITS_W   = 6;
   localparam int CODE_LEN_W    = 3;
   localparam int CHAR_W        = 8;
   localparam int STATUS_W      = 3;
   localparam int REQ_DATA_W    = 32;
   localparam int RSP_DATA_W    = 16;

   // message characters
   localparam logic [CHAR_W-1:0] SYM_DOT  = 8'h2E;
   localparam logic [CHAR_W-1:0] SYM_DASH = 8'h5F;
   localparam logic [CHAR_W-1:0] SYM_GAP  = 8'h20;

   // third space of a run marks a word gap
   localparam logic [1:0] GAP_WORD_AT = 2'd2;
   localparam logic [1:0] GAP_SAT     = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_LETTER  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_WORD    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_END     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

   // item kinds
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   // how the second stage forms its result
   typedef enum logic [2:0] {
      SRC_FLUSH,
      SRC_WORD,
      SRC_BAD,
      SRC_END,
      SRC_TAIL
   } src_type;

endpackage

`default_nettype wire

// File: sv/morse_symbol_decoder_core.sv
`default_nettype none

// a result reaches rsp_tvalid through the first stage register and then the output register
// throughput: one request per cycle while req_tready is high, table read and path update in the accept cycle
// the letter table is one single-port synchronous ram, at most one access per request
// reset: synchronous; afterwards a clearing sweep zeroes all 2^(MAX_CODE_LENGTH+1) table
// entries with req_tready low, then decoding starts at the root

module morse_symbol_decoder_core #(
   parameter int MAX_CODE_LENGTH = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // code_bits[5:0], code_length[8:6], letter[16:9], symbol[24:17], zero fill
   input  wire logic [31:0] req_tdata,
   // kind[0]
   input  wire logic        req_tuser,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_char[7:0], status[10:8], zero fill
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast
);

   localparam int ADDR_W = MAX_CODE_LENGTH + 1;
   localparam int DEPTH  = 1 << ADDR_W;

   // request fields
   logic [msd_pkg::CODE_BITS_W-1:0] code_bits;
   logic [msd_pkg::CODE_LEN_W-1:0]  code_length;
   logic [msd_pkg::CHAR_W-1:0]      letter;
   logic [msd_pkg::CHAR_W-1:0]      symbol;

   assign code_bits   = req_tdata[5:0];
   assign code_length = req_tdata[8:6];
   assign letter      = req_tdata[16:9];
   assign symbol      = req_tdata[24:17];

   // letter table and its read register
   logic [msd_pkg::CHAR_W-1:0] table_mem [DEPTH];
   logic [msd_pkg::CHAR_W-1:0] rd_ff;
   logic                       mem_we;
   logic                       mem_re;
   logic [ADDR_W-1:0]          mem_waddr;
   logic [msd_pkg::CHAR_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]          mem_raddr;

   // clearing sweep
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // decode state
   logic [ADDR_W-1:0] path_ff, path_in;
   logic              ovf_ff, ovf_in;
   logic [1:0]        gap_ff, gap_in;
   logic              drop_ff, drop_in;

   // first stage register
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_emit_ff, s1_emit_in;
   msd_pkg::src_type   s1_src_ff, s1_src_in;
   logic               s1_ovf_ff, s1_ovf_in;
   logic               s1_eom_ff, s1_eom_in;
   logic               s1_clear_ff, s1_clear_in;

   // second stage and output register
   logic                         nonempty_ff, nonempty_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [msd_pkg::CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [msd_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                         rsp_eom_ff, rsp_eom_in;

   logic              accept;
   logic              out_free;
   logic              s1_go;
   logic [ADDR_W-1:0] load_addr;
   logic              load_ok;
   logic              pending;
   logic              word_gap;

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || s1_go);
   assign accept     = req_tvalid && req_tready;

   // node address of a load path, first symbol nearest the root
   always_comb begin
      int len;
      int k;
      len       = int'(code_length);
      k         = 0;
      load_ok   = (len <= MAX_CODE_LENGTH);
      load_addr = '0;
      for (int p = 0; p < ADDR_W; p++) begin
         if (p == len) begin
            load_addr[p] = 1'b1;
         end else if (p < len) begin
            k = len - 1 - p;
            if (k < msd_pkg::CODE_BITS_W) begin
               load_addr[p] = code_bits[3'(k)];
            end
         end
      end
   end

   assign pending  = (path_ff != ADDR_W'(1)) || ovf_ff;
   assign word_gap = (gap_ff == msd_pkg::GAP_WORD_AT);

   // clearing sweep after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // first stage: path walk, table access and result plan
   always_comb begin
      path_in     = path_ff;
      ovf_in      = ovf_ff;
      gap_in      = gap_ff;
      drop_in     = drop_ff;
      s1_emit_in  = 1'b0;
      s1_src_in   = msd_pkg::SRC_END;
      s1_ovf_in   = 1'b0;
      s1_eom_in   = 1'b0;
      s1_clear_in = 1'b0;
      mem_we      = clr_busy_ff;
      mem_waddr   = clr_addr_ff;
      mem_wdata   = '0;
      mem_re      = 1'b0;
      mem_raddr   = path_ff;

      if (accept && req_tuser == msd_pkg::KIND_LOAD) begin
         if (load_ok) begin
            mem_we    = 1'b1;
            mem_waddr = load_addr;
            mem_wdata = letter;
         end
      end else if (accept) begin
         if (drop_ff) begin
            // rest of a bad message is dropped up to its last transfer
            if (req_tlast) begin
               s1_emit_in  = 1'b1;
               s1_src_in   = msd_pkg::SRC_END;
               s1_eom_in   = 1'b1;
               s1_clear_in = 1'b1;
            end
         end else if (symbol == msd_pkg::SYM_DOT || symbol == msd_pkg::SYM_DASH) begin
            gap_in = 2'd0;
            if (path_ff[ADDR_W-1]) begin
               ovf_in = 1'b1;
            end else begin
               path_in = {path_ff[ADDR_W-2:0], symbol == msd_pkg::SYM_DASH};
            end
            // last symbol flushes the extended path
            if (req_tlast) begin
               s1_emit_in  = 1'b1;
               s1_src_in   = msd_pkg::SRC_FLUSH;
               s1_ovf_in   = ovf_in;
               mem_re      = 1'b1;
               mem_raddr   = path_in;
               s1_eom_in   = 1'b1;
               s1_clear_in = 1'b1;
            end
         end else if (symbol == msd_pkg::SYM_GAP) begin
            if (pending) begin
               s1_emit_in = 1'b1;
               s1_src_in  = msd_pkg::SRC_FLUSH;
               s1_ovf_in  = ovf_ff;
               mem_re     = 1'b1;
            end
            if (word_gap) begin
               s1_emit_in = 1'b1;
               s1_src_in  = msd_pkg::SRC_WORD;
            end
            path_in = ADDR_W'(1);
            ovf_in  = 1'b0;
            if (gap_ff != msd_pkg::GAP_SAT) begin
               gap_in = gap_ff + 2'd1;
            end
            if (req_tlast) begin
               s1_emit_in  = 1'b1;
               if (!pending && !word_gap) begin
                  s1_src_in = msd_pkg::SRC_TAIL;
               end
               s1_eom_in   = 1'b1;
               s1_clear_in = 1'b1;
            end
         end else begin
            s1_emit_in = 1'b1;
            s1_src_in  = msd_pkg::SRC_BAD;
            s1_eom_in  = req_tlast;
            if (req_tlast) begin
               s1_clear_in = 1'b1;
            end else begin
               drop_in = 1'b1;
            end
         end

         // message state back to the root after its last transfer
         if (s1_clear_in) begin
            path_in = ADDR_W'(1);
            ovf_in  = 1'b0;
            gap_in  = 2'd0;
            drop_in = 1'b0;
         end
      end

      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   end

   // second stage: resolve table data into the result
   always_comb begin
      nonempty_in   = nonempty_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_status_in = rsp_status_ff;
      rsp_eom_in    = rsp_eom_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_go && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
         rsp_eom_in   = s1_eom_ff;
         rsp_char_in  = '0;
         unique case (s1_src_ff)
            msd_pkg::SRC_FLUSH: begin
               if (!s1_ovf_ff && rd_ff != '0) begin
                  rsp_char_in   = rd_ff;
                  rsp_status_in = msd_pkg::ST_LETTER;
                  nonempty_in   = 1'b1;
               end else begin
                  rsp_status_in = msd_pkg::ST_UNKNOWN;
               end
            end
            msd_pkg::SRC_WORD: begin
               rsp_char_in   = msd_pkg::SYM_GAP;
               rsp_status_in = msd_pkg::ST_WORD;
               nonempty_in   = 1'b1;
            end
            msd_pkg::SRC_BAD: begin
               rsp_status_in = msd_pkg::ST_BAD;
            end
            msd_pkg::SRC_TAIL: begin
               rsp_status_in = nonempty_ff ? msd_pkg::ST_END : msd_pkg::ST_EMPTY;
            end
            default: begin
               rsp_status_in = msd_pkg::ST_END;
            end
         endcase
      end

      if (s1_go && s1_clear_ff) begin
         nonempty_in = 1'b0;
      end
   end

   // letter table ram
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= table_mem[mem_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         path_ff      <= ADDR_W'(1);
         ovf_ff       <= 1'b0;
         gap_ff       <= 2'd0;
         drop_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         path_ff      <= path_in;
         ovf_ff       <= ovf_in;
         gap_ff       <= gap_in;
         drop_ff      <= drop_in;
         s1_valid_ff  <= s1_valid_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff  <= s1_emit_in;
         s1_src_ff   <= s1_src_in;
         s1_ovf_ff   <= s1_ovf_in;
         s1_eom_ff   <= s1_eom_in;
         s1_clear_ff <= s1_clear_in;
      end
      rsp_char_ff   <= rsp_char_in;
      rsp_status_ff <= rsp_status_in;
      rsp_eom_ff    <= rsp_eom_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_status_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_eom_ff;

   // no request taken while the table is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("request taken during table clear");

   // the path never leaves the tree
   a_path_nonzero: assert property (@(posedge clock) disable iff (reset)
      path_ff != '0)
      else $error("path index lost its root bit");

   // only letters and word spaces carry a character
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != msd_pkg::ST_LETTER
         && rsp_status_ff != msd_pkg::ST_WORD |-> rsp_char_ff == '0)
      else $error("character on a status result");

   // a word space always carries a space
   a_word_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == msd_pkg::ST_WORD |-> rsp_char_ff == msd_pkg::SYM_GAP)
      else $error("word space without space character");

   // a stalled result is held until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_char_ff)
         && $stable(rsp_status_ff))
      else $error("stalled result changed");

endmodule

`default_nettype wire
